// ===== rtl/heose_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heose_pkg
// Types, codes and constants shared by the hold-then-ease-out scale envelope.
// ----------------------------------------------------------------------------
package heose_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   localparam int SCALE_W = 16;   // Q4.12 scale
   localparam int FRAC_W  = 16;   // Q0.16 shrink progress
   localparam int DIV_STEPS = FRAC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [SCALE_W-1:0] ONE_Q12 = 16'h1000;

   localparam logic [15:0] PEAK_RESET   = 16'd12288;
   localparam logic [15:0] HOLD_RESET   = 16'd500;
   localparam logic [15:0] SHRINK_RESET = 16'd300;

   // register indexes
   localparam logic [1:0] CSR_PEAK   = 2'd0;
   localparam logic [1:0] CSR_HOLD   = 2'd1;
   localparam logic [1:0] CSR_SHRINK = 2'd2;

   // event kinds
   localparam logic [1:0] KIND_TRIGGER = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_STOP    = 2'd2;

   // result actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_APPLY   = 2'd1;
   localparam logic [1:0] ACT_RESTORE = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [SCALE_W-1:0] scale;
      logic               animating;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_HOLD,
      MODE_SHRINK
   } mode_type;

   typedef enum logic [3:0] {
      FS_WAIT,
      FS_DECIDE,
      FS_DIV,
      FS_MUL_SQ,
      FS_MUL_CUBE,
      FS_MUL_LO,
      FS_MUL_HI,
      FS_SCALE,
      FS_SEND
   } fsm_type;

   typedef enum logic [1:0] {
      PH_KEEP,
      PH_NOW,
      PH_CLEAR
   } phase_op_type;

   typedef enum logic [1:0] {
      SC_KEEP,
      SC_PEAK,
      SC_ONE,
      SC_EASE
   } scale_op_type;

   typedef enum logic [2:0] {
      MO_NONE,
      MO_SQ,
      MO_CUBE,
      MO_LO,
      MO_HI
   } mul_op_type;

   typedef struct packed {
      logic         req_load;
      phase_op_type phase_op;
      scale_op_type scale_op;
      logic         div_init;
      logic         div_step;
      mul_op_type   mul_op;
      logic         rsp_load;
      logic [1:0]   action;
      logic         animating;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       hold_hit;
      logic       shrink_end;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/heose_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heose_ctrl
// Sequencer: envelope mode, event decode, divide/multiply sequencing and the
// result handshake.
// ----------------------------------------------------------------------------
module heose_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire heose_pkg::status_type status,
   output heose_pkg::cmd_type        cmd
);

   heose_pkg::fsm_type  state_ff, state_in;
   heose_pkg::mode_type mode_ff, mode_in;
   logic [1:0]          action_ff, action_in;
   logic [heose_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == heose_pkg::FS_WAIT);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= heose_pkg::FS_WAIT;
         mode_ff      <= heose_pkg::MODE_IDLE;
         action_ff    <= heose_pkg::ACT_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         action_ff    <= action_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         heose_pkg::FS_WAIT: begin
            if (req_valid) state_in = heose_pkg::FS_DECIDE;
         end
         heose_pkg::FS_DECIDE: begin
            if (status.kind == heose_pkg::KIND_TICK && mode_ff == heose_pkg::MODE_SHRINK
                && !status.shrink_end) begin
               state_in = heose_pkg::FS_DIV;
            end else begin
               state_in = heose_pkg::FS_SEND;
            end
         end
         heose_pkg::FS_DIV: begin
            if (cnt_ff == heose_pkg::DIV_CNT_W'(heose_pkg::DIV_STEPS - 1)) begin
               state_in = heose_pkg::FS_MUL_SQ;
            end
         end
         heose_pkg::FS_MUL_SQ:   state_in = heose_pkg::FS_MUL_CUBE;
         heose_pkg::FS_MUL_CUBE: state_in = heose_pkg::FS_MUL_LO;
         heose_pkg::FS_MUL_LO:   state_in = heose_pkg::FS_MUL_HI;
         heose_pkg::FS_MUL_HI:   state_in = heose_pkg::FS_SCALE;
         heose_pkg::FS_SCALE:    state_in = heose_pkg::FS_SEND;
         heose_pkg::FS_SEND: begin
            if (slot_free) state_in = heose_pkg::FS_WAIT;
         end
         default: state_in = heose_pkg::FS_WAIT;
      endcase
   end

   // outputs and mode update
   always_comb begin
      cmd          = '0;
      cmd.phase_op = heose_pkg::PH_KEEP;
      cmd.scale_op = heose_pkg::SC_KEEP;
      cmd.mul_op   = heose_pkg::MO_NONE;
      cmd.action    = action_ff;
      cmd.animating = (mode_ff != heose_pkg::MODE_IDLE);
      mode_in      = mode_ff;
      action_in    = action_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         heose_pkg::FS_WAIT: begin
            cmd.req_load = req_valid;
         end
         heose_pkg::FS_DECIDE: begin
            action_in = heose_pkg::ACT_NONE;
            case (status.kind)
               heose_pkg::KIND_TRIGGER: begin
                  cmd.phase_op = heose_pkg::PH_NOW;
                  cmd.scale_op = heose_pkg::SC_PEAK;
                  mode_in      = heose_pkg::MODE_HOLD;
                  action_in    = heose_pkg::ACT_APPLY;
               end
               heose_pkg::KIND_TICK: begin
                  if (mode_ff == heose_pkg::MODE_HOLD) begin
                     if (status.hold_hit) begin
                        cmd.phase_op = heose_pkg::PH_NOW;
                        mode_in      = heose_pkg::MODE_SHRINK;
                     end
                  end else if (mode_ff == heose_pkg::MODE_SHRINK) begin
                     if (status.shrink_end) begin
                        cmd.scale_op = heose_pkg::SC_ONE;
                        mode_in      = heose_pkg::MODE_IDLE;
                        action_in    = heose_pkg::ACT_RESTORE;
                     end else begin
                        cmd.div_init = 1'b1;
                        cnt_in       = '0;
                        action_in    = heose_pkg::ACT_APPLY;
                     end
                  end
               end
               heose_pkg::KIND_STOP: begin
                  if (mode_ff != heose_pkg::MODE_IDLE) action_in = heose_pkg::ACT_RESTORE;
                  cmd.phase_op = heose_pkg::PH_CLEAR;
                  cmd.scale_op = heose_pkg::SC_ONE;
                  mode_in      = heose_pkg::MODE_IDLE;
               end
               default: ;  // unknown kind: report state unchanged
            endcase
         end
         heose_pkg::FS_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         heose_pkg::FS_MUL_SQ:   cmd.mul_op = heose_pkg::MO_SQ;
         heose_pkg::FS_MUL_CUBE: cmd.mul_op = heose_pkg::MO_CUBE;
         heose_pkg::FS_MUL_LO:   cmd.mul_op = heose_pkg::MO_LO;
         heose_pkg::FS_MUL_HI:   cmd.mul_op = heose_pkg::MO_HI;
         heose_pkg::FS_SCALE:    cmd.scale_op = heose_pkg::SC_EASE;
         heose_pkg::FS_SEND: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/heose_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heose_dp
// Datapath: request latch, phase timer, radix-2 divider for shrink progress,
// sequenced cubic ease-out multiplies and the result register.
// ----------------------------------------------------------------------------
module heose_dp #(
   parameter int TIME_BITS = heose_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire heose_pkg::req_type  req_data,
   input  wire logic [15:0]         peak_scale,
   input  wire logic [15:0]         hold_ms,
   input  wire logic [15:0]         shrink_ms,
   input  wire heose_pkg::cmd_type  cmd,
   output heose_pkg::status_type    status,
   output heose_pkg::rsp_type       rsp_data
);

   localparam logic [48:0] CUBE_ONE = 49'h1_0000_0000_0000;  // 1.0 in Q0.48
   localparam logic [16:0] FRAC_ONE = 17'h1_0000;            // 1.0 in Q0.16

   logic [1:0]           kind_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] phase_ff;
   logic [15:0]          scale_ff;
   logic [15:0]          rem_ff;
   logic [15:0]          quo_ff;
   logic [32:0]          sq_ff;
   logic [48:0]          cube_ff;
   logic [39:0]          lo_ff;
   logic [39:0]          hi_ff;
   heose_pkg::rsp_type   rsp_ff;

   logic [TIME_BITS-1:0] elapsed;
   logic [15:0]          peak_eff;
   logic [15:0]          peak_delta;
   logic [16:0]          rem_shift;
   logic                 rem_ge;
   logic [16:0]          rem_sub;
   logic [16:0]          inv;
   logic [33:0]          sq_full;
   logic [49:0]          cube_full;
   logic [48:0]          eased;
   logic [39:0]          lo_full;
   logic [39:0]          hi_full;
   logic [40:0]          drop_sum;
   logic [15:0]          drop;

   assign elapsed    = now_ff - phase_ff;
   assign peak_eff   = (peak_scale < heose_pkg::ONE_Q12) ? heose_pkg::ONE_Q12 : peak_scale;
   assign peak_delta = peak_eff - heose_pkg::ONE_Q12;

   assign status.kind       = kind_ff;
   assign status.hold_hit   = (elapsed >= TIME_BITS'(hold_ms));
   assign status.shrink_end = (shrink_ms == 16'd0) || (elapsed >= TIME_BITS'(shrink_ms));

   // one restoring divide step: remainder stays below shrink_ms
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, shrink_ms});
   assign rem_sub   = rem_shift - {1'b0, shrink_ms};

   assign inv       = FRAC_ONE - {1'b0, quo_ff};
   assign sq_full   = inv * inv;
   assign cube_full = sq_ff * inv;
   assign eased     = CUBE_ONE - cube_ff;
   assign lo_full   = eased[23:0] * peak_delta;
   assign hi_full   = eased[47:24] * peak_delta;
   // floor((hi*2^24 + lo) / 2^48)
   assign drop_sum  = {1'b0, hi_ff} + {25'd0, lo_ff[39:24]};
   assign drop      = drop_sum[39:24];

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         kind_ff <= req_data.kind;
         now_ff  <= TIME_BITS'(req_data.now_ms);
      end
      if (cmd.div_init) begin
         rem_ff <= elapsed[15:0];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[15:0] : rem_shift[15:0];
         quo_ff <= {quo_ff[14:0], rem_ge};
      end
      case (cmd.mul_op)
         heose_pkg::MO_SQ:   sq_ff   <= sq_full[32:0];
         heose_pkg::MO_CUBE: cube_ff <= cube_full[48:0];
         heose_pkg::MO_LO:   lo_ff   <= lo_full;
         heose_pkg::MO_HI:   hi_ff   <= hi_full;
         default: ;
      endcase
      if (cmd.rsp_load) begin
         rsp_ff.action    <= cmd.action;
         rsp_ff.scale     <= scale_ff;
         rsp_ff.animating <= cmd.animating;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         scale_ff <= heose_pkg::ONE_Q12;
      end else begin
         case (cmd.phase_op)
            heose_pkg::PH_NOW:   phase_ff <= now_ff;
            heose_pkg::PH_CLEAR: phase_ff <= '0;
            default: ;
         endcase
         case (cmd.scale_op)
            heose_pkg::SC_PEAK: scale_ff <= peak_eff;
            heose_pkg::SC_ONE:  scale_ff <= heose_pkg::ONE_Q12;
            heose_pkg::SC_EASE: scale_ff <= peak_eff - drop;
            default: ;
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/hold_then_ease_out_scale_envelope.sv =====
`default_nettype none
// Requests are handled one at a time: req_ready is high only in the wait state.
// Trigger, stop, hold ticks and the final shrink tick go through decide and send;
// a shrink tick that eases also runs the 16-step radix-2 divider and four
// sequenced multiplies. A result still waiting in the output register holds off
// the next request.
// Reset (synchronous): mode idle, scale 1.0, phase start 0, registers to defaults.
// ----------------------------------------------------------------------------
// hold_then_ease_out_scale_envelope
// Trigger/tick/stop driven scale envelope: hold at peak, then cubic ease-out
// back to 1.0 (Q4.12).
// ----------------------------------------------------------------------------
module hold_then_ease_out_scale_envelope #(
   parameter int TIME_BITS = heose_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire heose_pkg::req_type  req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output heose_pkg::rsp_type       rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);

   logic [15:0] peak_ff;
   logic [15:0] hold_ff;
   logic [15:0] shrink_ff;

   heose_pkg::cmd_type    cmd;
   heose_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= heose_pkg::PEAK_RESET;
         hold_ff   <= heose_pkg::HOLD_RESET;
         shrink_ff <= heose_pkg::SHRINK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            heose_pkg::CSR_PEAK:   peak_ff   <= csr_wdata;
            heose_pkg::CSR_HOLD:   hold_ff   <= csr_wdata;
            heose_pkg::CSR_SHRINK: shrink_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   heose_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   heose_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .peak_scale (peak_ff),
      .hold_ms    (hold_ff),
      .shrink_ms  (shrink_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hold-then-ease-out scale envelope. Trigger,
// tick and stop requests are queued by a stimulus process and sent by a
// clocked driver. A built-in envelope predictor computes each expected
// response, and a clocked monitor compares every response field by field.
// Runs go through several register settings, extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_EVENTS = 205;
   localparam int LONG_STALL = 300;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   heose_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   heose_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // envelope predictor state and register copies
   logic [15:0] cfg_peak = heose_pkg::PEAK_RESET;
   logic [15:0] cfg_hold = heose_pkg::HOLD_RESET;
   logic [15:0] cfg_shrink = heose_pkg::SHRINK_RESET;
   heose_pkg::mode_type env_mode = heose_pkg::MODE_IDLE;
   logic [31:0] env_start = '0;
   logic [15:0] env_scale = heose_pkg::ONE_Q12;

   heose_pkg::req_type ev_backlog[$];
   heose_pkg::rsp_type due_results[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int recv_hold = 0;
   int stall_asks = 0;
   int stall_served = 0;
   int phase_events = 0;
   bit calm = 1'b0;
   logic [31:0] wall_ms = '0;

   hold_then_ease_out_scale_envelope dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic heose_pkg::rsp_type envelope_next(heose_pkg::req_type ev);
      logic [31:0] elapsed;
      logic [15:0] peak_eff;
      logic [63:0] frac, inv, eased, drop;
      heose_pkg::rsp_type res;
      elapsed = ev.now_ms - env_start;
      peak_eff = (cfg_peak < heose_pkg::ONE_Q12) ? heose_pkg::ONE_Q12 : cfg_peak;
      res.action = heose_pkg::ACT_NONE;
      case (ev.kind)
         heose_pkg::KIND_TRIGGER: begin
            env_start = ev.now_ms;
            env_scale = peak_eff;
            env_mode = heose_pkg::MODE_HOLD;
            res.action = heose_pkg::ACT_APPLY;
         end
         heose_pkg::KIND_TICK: begin
            if (env_mode == heose_pkg::MODE_HOLD) begin
               if (elapsed >= cfg_hold) begin
                  env_start = ev.now_ms;
                  env_mode = heose_pkg::MODE_SHRINK;
               end
            end else if (env_mode == heose_pkg::MODE_SHRINK) begin
               if (cfg_shrink == 16'd0 || elapsed >= cfg_shrink) begin
                  env_scale = heose_pkg::ONE_Q12;
                  env_mode = heose_pkg::MODE_IDLE;
                  res.action = heose_pkg::ACT_RESTORE;
               end else begin
                  // exact cubic ease-out: progress Q0.16, cube Q0.48
                  frac = {16'h0, elapsed, 16'h0} / {48'h0, cfg_shrink};
                  inv = 64'd65536 - frac;
                  eased = (64'd1 << 48) - inv * inv * inv;
                  drop = (eased * {48'h0, peak_eff - heose_pkg::ONE_Q12}) >> 48;
                  env_scale = peak_eff - drop[15:0];
                  res.action = heose_pkg::ACT_APPLY;
               end
            end
         end
         heose_pkg::KIND_STOP: begin
            if (env_mode != heose_pkg::MODE_IDLE) res.action = heose_pkg::ACT_RESTORE;
            env_mode = heose_pkg::MODE_IDLE;
            env_start = '0;
            env_scale = heose_pkg::ONE_Q12;
         end
         default: ;
      endcase
      res.scale = env_scale;
      res.animating = (env_mode != heose_pkg::MODE_IDLE);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) due_results.push_back(envelope_next(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (ev_backlog.size() != 0) begin
               req_data <= ev_backlog.pop_front();
               req_valid <= 1'b1;
               send_gap = calm ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_served != stall_asks) begin
         stall_served = stall_asks;
         recv_hold = LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold = recv_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_hold = calm ? 0 : pick_gap();
      end
   end

   // response monitor
   always @(posedge clock) begin
      heose_pkg::rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("response with no request outstanding: action %0d scale %0d",
                   rsp_data.action, rsp_data.scale);
            fail_count++;
         end else begin
            due = due_results.pop_front();
            if (rsp_data.action !== due.action) begin
               $error("action mismatch: expected %0d, actual %0d", due.action,
                      rsp_data.action);
               fail_count++;
            end
            if (rsp_data.scale !== due.scale) begin
               $error("scale mismatch: expected %0d, actual %0d", due.scale,
                      rsp_data.scale);
               fail_count++;
            end
            if (rsp_data.animating !== due.animating) begin
               $error("animating mismatch: expected %0d, actual %0d", due.animating,
                      rsp_data.animating);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_req(logic [1:0] k, logic [31:0] ts);
      heose_pkg::req_type ev;
      ev.kind = k;
      ev.now_ms = ts;
      ev_backlog.push_back(ev);
      if (k != KIND_UNKNOWN) phase_events++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         heose_pkg::CSR_PEAK: cfg_peak = val;
         heose_pkg::CSR_HOLD: cfg_hold = val;
         heose_pkg::CSR_SHRINK: cfg_shrink = val;
         default: ;
      endcase
   endtask

   // checked at the falling edge so the driver's updates have settled
   task automatic drain_all();
      while (ev_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
   endtask

   // one trigger / hold / shrink / restore cycle, sometimes cut short
   task automatic envelope_run();
      logic [31:0] t0, t1, e;
      int n, sel;
      t0 = wall_ms;
      push_req(heose_pkg::KIND_TRIGGER, t0);
      n = $urandom_range(0, 3);
      if (cfg_hold != 16'd0)
         repeat (n) push_req(heose_pkg::KIND_TICK, t0 + $urandom_range(0, cfg_hold - 1));
      t1 = t0 + cfg_hold + (($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 50));
      push_req(heose_pkg::KIND_TICK, t1);
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
         push_req(heose_pkg::KIND_STOP, t1 + $urandom_range(0, 40));
      end else if (sel == 1) begin
         push_req(heose_pkg::KIND_TRIGGER, t1 + $urandom_range(0, 40));
         push_req(heose_pkg::KIND_STOP, t1 + $urandom_range(40, 80));
      end else begin
         if (cfg_shrink != 16'd0) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               sel = $urandom_range(0, 9);
               if (sel == 0) e = 0;
               else if (sel == 1) e = cfg_shrink - 1;
               else e = $urandom_range(0, cfg_shrink - 1);
               push_req(heose_pkg::KIND_TICK, t1 + e);
            end
         end
         push_req(heose_pkg::KIND_TICK, t1 + cfg_shrink + $urandom_range(0, 20));
      end
      wall_ms = t1 + cfg_shrink + $urandom_range(21, 500);
   endtask

   task automatic noise_req();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: push_req(heose_pkg::KIND_TICK, wall_ms + $urandom_range(0, 2000));
         3: push_req(heose_pkg::KIND_STOP, wall_ms);
         4: push_req(KIND_UNKNOWN, $urandom);
         5: push_req(2'($urandom_range(0, 3)), $urandom);
         6: push_req(heose_pkg::KIND_TRIGGER, wall_ms);
         7: begin
            wall_ms = $urandom;
            push_req(heose_pkg::KIND_TICK, wall_ms);
         end
         default: push_req(heose_pkg::KIND_TICK, wall_ms + $urandom_range(0, 70000));
      endcase
   endtask

   initial begin
      logic [15:0] pk, hd, sh;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed requests on reset settings (peak 3.0, hold 500, shrink 300)
      push_req(heose_pkg::KIND_TICK, 32'd0);
      push_req(heose_pkg::KIND_STOP, 32'd0);
      push_req(KIND_UNKNOWN, 32'd0);
      push_req(heose_pkg::KIND_TRIGGER, 32'd1000);
      push_req(heose_pkg::KIND_TICK, 32'd1499);
      push_req(heose_pkg::KIND_TICK, 32'd1500);
      push_req(heose_pkg::KIND_TICK, 32'd1500);
      push_req(heose_pkg::KIND_TICK, 32'd1501);
      push_req(heose_pkg::KIND_TICK, 32'd1650);
      push_req(heose_pkg::KIND_TICK, 32'd1799);
      push_req(KIND_UNKNOWN, 32'd1799);
      push_req(heose_pkg::KIND_TICK, 32'd1800);
      push_req(heose_pkg::KIND_TRIGGER, 32'd2000);
      push_req(heose_pkg::KIND_TRIGGER, 32'd2100);
      push_req(heose_pkg::KIND_STOP, 32'd2200);
      // timestamps wrapping past zero
      push_req(heose_pkg::KIND_TRIGGER, 32'hFFFF_FF00);
      push_req(heose_pkg::KIND_TICK, 32'h0000_01F4);
      push_req(heose_pkg::KIND_TICK, 32'h0000_031F);
      push_req(heose_pkg::KIND_TICK, 32'hFFFF_FFFF);
      push_req(heose_pkg::KIND_TICK, 32'hFFFF_FFFF);
      push_req(KIND_UNKNOWN, 32'hFFFF_FFFF);
      drain_all();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin pk = 16'hFFFF; hd = 16'd0; sh = 16'd1; end
            1: begin pk = 16'd4095; hd = 16'hFFFF; sh = 16'd0; end
            2: begin pk = heose_pkg::ONE_Q12; hd = 16'd1; sh = 16'hFFFF; end
            3: begin
               pk = 16'd0;
               hd = 16'($urandom_range(0, 3000));
               sh = 16'($urandom_range(1, 3000));
            end
            default: begin
               pk = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 4095))
                                                 : 16'($urandom_range(4096, 65535));
               hd = 16'($urandom_range(0, 2000));
               sh = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
            end
         endcase
         write_reg(heose_pkg::CSR_PEAK, pk);
         write_reg(heose_pkg::CSR_HOLD, hd);
         write_reg(heose_pkg::CSR_SHRINK, sh);
         if (ph == 4) write_reg(CSR_UNUSED, 16'($urandom));
         calm = (ph == 3);
         // hold the response side off so requests back up into the block
         if (ph == 1 || ph == 5) stall_asks++;
         phase_events = 0;
         wall_ms = $urandom;
         while (phase_events < PHASE_EVENTS) begin
            if ($urandom_range(0, 9) < 8) envelope_run();
            else noise_req();
         end
         drain_all();
      end
      calm = 1'b0;

      drain_all();
      repeat (30) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d responses never arrived", due_results.size());
         fail_count++;
      end
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
